// ----- sv/ogru_pkg.sv -----
package ogru_pkg;

	// Input operation codes
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_RAY   = 2'd1,
		OP_HIT   = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_OCC_WEIGHT  = 1'b0,
		REG_FREE_WEIGHT = 1'b1
	} cfg_idx_t;

	// Kind of access made to one cell
	typedef enum logic [1:0] {
		KIND_FREE = 2'd0,
		KIND_HIT  = 2'd1,
		KIND_READ = 2'd2
	} kind_t;

	localparam int unsigned COORD_W  = 16;
	localparam int unsigned WEIGHT_W = 7;
	localparam int unsigned CELL_W   = 8;
	localparam int unsigned COUNT_W  = 16;
	// Error term of the line walk: covers minus twice to plus twice the span
	localparam int unsigned ERR_W    = 19;
	// Frame tag stored with each cell in place of a visited bit
	localparam int unsigned EPOCH_W  = 8;

	localparam logic [CELL_W-1:0] CELL_UNKNOWN = 8'd128;
	localparam logic [CELL_W-1:0] OCC_LOWER    = 8'd118;
	localparam logic [CELL_W-1:0] FREE_UPPER   = 8'd138;

	// One cell access handed from the walker to the cell store
	typedef struct packed {
		logic               valid;
		logic               last;
		logic               skip;
		kind_t              kind;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} req_t;

	// Outcome of one cell access
	typedef struct packed {
		logic              valid;
		logic              last;
		logic              acc;
		logic [CELL_W-1:0] value;
	} rsp_t;

endpackage

// ----- sv/occupancy_grid_ray_update_unit.sv -----
// Occupancy grid ray update. Raise start with op, cell_x and cell_y while busy is low; one
// result comes back on done, cell_value and cells_changed for exactly one cycle and cannot
// be held off. A start frame answers in the next cycle. A hit or a read passes the prep
// and request registers of the walker and the access register of the cell store before
// done; a free ray first walks max(|dx|, |dy|) cells, dx and dy measured from the sensor
// cell: the walk reads, updates and writes one cell per cycle through the cell and frame
// tag memories, each with one read and one write port, so the ray span sets the time.
// After reset busy stays high while every cell is set to 128; every 255th start frame
// clears the frame tags in a sweep over all cells (the result comes at once, busy stays
// high). Configuration writes are taken in any cycle.
module occupancy_grid_ray_update_unit
	import ogru_pkg::*;
#(
	parameter int unsigned GRID_WIDTH  = 256,
	parameter int unsigned GRID_HEIGHT = 256
)(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                op,
	input  logic signed [COORD_W-1:0] cell_x,
	input  logic signed [COORD_W-1:0] cell_y,
	output logic                      done,
	output logic [CELL_W-1:0]         cell_value,
	output logic [COUNT_W-1:0]        cells_changed,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_idx,
	input  logic [WEIGHT_W-1:0]       cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                    state_q;
	op_t                       op_q;
	logic signed [COORD_W-1:0] sensor_x_q, sensor_y_q;
	logic [WEIGHT_W-1:0]       occ_weight_q, free_weight_q;
	logic [COUNT_W-1:0]        count_q;
	logic                      done_q;
	logic [CELL_W-1:0]         cell_value_q;
	logic [COUNT_W-1:0]        cells_changed_q;

	logic                      accept;
	logic                      load;
	logic                      new_frame;
	logic                      sweep_busy;
	op_t                       op_in;
	req_t                      req;
	rsp_t                      rsp;
	logic [COUNT_W-1:0]        count_next;

	assign op_in      = op_t'(op);
	assign busy       = (state_q != ST_IDLE) || sweep_busy;
	assign accept     = start && !busy;
	assign new_frame  = accept && (op_in == OP_START);
	assign load       = accept && (op_in != OP_START);
	assign count_next = count_q + COUNT_W'(rsp.acc);

	ogru_ray_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.load_op  (op_in),
		.sensor_x (sensor_x_q),
		.sensor_y (sensor_y_q),
		.end_x    (cell_x),
		.end_y    (cell_y),
		.req      (req)
	);

	ogru_cell_store #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.occ_weight  (occ_weight_q),
		.free_weight (free_weight_q),
		.new_frame   (new_frame),
		.rsp         (rsp),
		.sweep_busy  (sweep_busy)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_weight_q  <= WEIGHT_W'(10);
			free_weight_q <= WEIGHT_W'(3);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				REG_OCC_WEIGHT:  occ_weight_q  <= cfg_data;
				REG_FREE_WEIGHT: free_weight_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Item control: take an item, latch the sensor cell on a start frame, signal the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			done_q     <= 1'b0;
			sensor_x_q <= '0;
			sensor_y_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (new_frame) begin
						sensor_x_q <= cell_x;
						sensor_y_q <= cell_y;
						done_q     <= 1'b1;
					end else if (load) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (rsp.valid && rsp.last) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_in;
			count_q <= '0;
		end else if (rsp.valid) begin
			count_q <= count_next;
		end
		if (new_frame) begin
			cell_value_q    <= '0;
			cells_changed_q <= '0;
		end else if (rsp.valid && rsp.last) begin
			cell_value_q    <= rsp.value;
			cells_changed_q <= count_next;
		end
	end

	assign done          = done_q;
	assign cell_value    = cell_value_q;
	assign cells_changed = cells_changed_q;

	a_rsp_only_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> state_q == ST_RUN)
		else $error("cell outcome with no item in flight");

	a_no_count_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (op_q == OP_START || op_q == OP_READ) |-> cells_changed_q == '0)
		else $error("cells counted for an item that updates nothing");

	a_value_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && op_q != OP_READ |-> cell_value_q == '0)
		else $error("cell value returned for an item that is not a read");

endmodule

// ----- sv/ogru_ray_step.sv -----
module ogru_ray_step
	import ogru_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  op_t                       load_op,
	input  logic signed [COORD_W-1:0] sensor_x,
	input  logic signed [COORD_W-1:0] sensor_y,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	output req_t                      req
);

	logic                      prep_q;
	logic                      active_q;
	kind_t                     kind_q;
	logic signed [COORD_W:0]   dx_q, dy_q;
	logic [COORD_W-1:0]        sx_q, sy_q, ex_q, ey_q;
	logic [COORD_W-1:0]        rem_q;
	logic [COORD_W-1:0]        x_q, y_q;
	logic signed [ERR_W-1:0]   e_q, inc_a_q, inc_b_q;
	logic                      xmaj_q, xneg_q, yneg_q;
	req_t                      req_q;

	logic [COORD_W:0]          adx_w, ady_w;
	logic [COORD_W-1:0]        adx, ady, major, minor;
	logic                      xmaj;
	logic signed [ERR_W-1:0]   inc_a, inc_b, e_init;
	logic [COORD_W-1:0]        x_step, y_step, x_next, y_next;
	logic signed [ERR_W-1:0]   en_a, en_b, e_next;
	logic                      move_minor;
	kind_t                     load_kind;

	// Map the operation onto a cell access kind
	always_comb begin
		case (load_op)
			OP_HIT:  load_kind = KIND_HIT;
			OP_READ: load_kind = KIND_READ;
			default: load_kind = KIND_FREE;
		endcase
	end

	// Span set-up: magnitudes, major axis and error increments
	always_comb begin
		adx_w  = dx_q[COORD_W] ? (~dx_q + 1'b1) : dx_q;
		ady_w  = dy_q[COORD_W] ? (~dy_q + 1'b1) : dy_q;
		adx    = adx_w[COORD_W-1:0];
		ady    = ady_w[COORD_W-1:0];
		xmaj   = adx > ady;
		major  = xmaj ? adx : ady;
		minor  = xmaj ? ady : adx;
		inc_a  = $signed({2'b00, minor, 1'b0});
		inc_b  = $signed({2'b00, minor, 1'b0}) - $signed({2'b00, major, 1'b0});
		e_init = -$signed({3'b000, major});
	end

	// One step of the line: major axis always moves, minor axis on error
	always_comb begin
		x_step     = x_q + (xneg_q ? {COORD_W{1'b1}} : COORD_W'(1));
		y_step     = y_q + (yneg_q ? {COORD_W{1'b1}} : COORD_W'(1));
		en_a       = e_q + inc_a_q;
		en_b       = e_q + inc_b_q;
		move_minor = !en_a[ERR_W-1];
		e_next     = move_minor ? en_b : en_a;
		x_next     = (xmaj_q || move_minor) ? x_step : x_q;
		y_next     = (!xmaj_q || move_minor) ? y_step : y_q;
	end

	// Latch the item, set up the walk, then emit one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_q   <= 1'b0;
			active_q <= 1'b0;
			req_q    <= '0;
		end else begin
			req_q.valid <= 1'b0;
			prep_q      <= load;
			if (prep_q) begin
				if (kind_q == KIND_FREE && major != '0) begin
					active_q <= 1'b1;
				end else begin
					// single cell, or a ray to the sensor cell with no step
					req_q.valid <= 1'b1;
					req_q.last  <= 1'b1;
					req_q.skip  <= (kind_q == KIND_FREE);
					req_q.kind  <= kind_q;
					req_q.x     <= ex_q;
					req_q.y     <= ey_q;
				end
			end else if (active_q) begin
				// the walk reaches the endpoint only on its final step
				req_q.valid <= 1'b1;
				req_q.last  <= (rem_q == COORD_W'(1));
				req_q.skip  <= (rem_q == COORD_W'(1));
				req_q.kind  <= KIND_FREE;
				req_q.x     <= x_next;
				req_q.y     <= y_next;
				if (rem_q == COORD_W'(1))
					active_q <= 1'b0;
			end
		end
	end

	// Walk datapath
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= load_kind;
			dx_q   <= $signed({end_x[COORD_W-1], end_x}) - $signed({sensor_x[COORD_W-1], sensor_x});
			dy_q   <= $signed({end_y[COORD_W-1], end_y}) - $signed({sensor_y[COORD_W-1], sensor_y});
			sx_q   <= sensor_x;
			sy_q   <= sensor_y;
			ex_q   <= end_x;
			ey_q   <= end_y;
		end
		if (prep_q) begin
			x_q     <= sx_q;
			y_q     <= sy_q;
			rem_q   <= major;
			e_q     <= e_init;
			inc_a_q <= inc_a;
			inc_b_q <= inc_b;
			xmaj_q  <= xmaj;
			xneg_q  <= dx_q[COORD_W] || (dx_q == '0);
			yneg_q  <= dy_q[COORD_W] || (dy_q == '0);
		end else if (active_q) begin
			x_q   <= x_next;
			y_q   <= y_next;
			e_q   <= e_next;
			rem_q <= rem_q - 1'b1;
		end
	end

	assign req = req_q;

endmodule

// ----- sv/ogru_cell_store.sv -----
module ogru_cell_store
	import ogru_pkg::*;
#(
	parameter int unsigned GRID_WIDTH  = 256,
	parameter int unsigned GRID_HEIGHT = 256
)(
	input  logic                clk,
	input  logic                arst_n,
	input  req_t                req,
	input  logic [WEIGHT_W-1:0] occ_weight,
	input  logic [WEIGHT_W-1:0] free_weight,
	input  logic                new_frame,
	output rsp_t                rsp,
	output logic                sweep_busy
);

	localparam int unsigned CELLS = GRID_WIDTH * GRID_HEIGHT;
	localparam int unsigned AW    = $clog2(CELLS);
	localparam int unsigned XW    = $clog2(GRID_WIDTH);
	localparam int unsigned YW    = $clog2(GRID_HEIGHT);
	localparam logic [AW-1:0] WIDTH_A   = AW'(GRID_WIDTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
	localparam logic [COORD_W-2:0] X_LIM = (COORD_W-1)'(GRID_WIDTH);
	localparam logic [COORD_W-2:0] Y_LIM = (COORD_W-1)'(GRID_HEIGHT);

	typedef struct packed {
		logic          valid;
		logic          last;
		logic          skip;
		logic          inb;
		kind_t         kind;
		logic [AW-1:0] addr;
	} s1_t;

	logic [CELL_W-1:0]  grid_mem [CELLS];
	logic [EPOCH_W-1:0] mark_mem [CELLS];

	logic [CELL_W-1:0]  grid_rd_q;
	logic [EPOCH_W-1:0] mark_rd_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic               sweep_q, sweep_grid_q;
	logic [AW-1:0]      sweep_addr_q;
	s1_t                s1_q;

	logic               req_inb;
	logic [AW-1:0]      rd_addr;
	logic               live;
	logic [CELL_W-1:0]  cur, upd;
	logic [CELL_W:0]    sum;
	logic               grid_we, mark_we;
	logic [AW-1:0]      wr_addr;
	logic [CELL_W-1:0]  grid_wd;
	logic [EPOCH_W-1:0] mark_wd;

	// Grid bounds and linear address of the requested cell
	always_comb begin
		req_inb = !req.x[COORD_W-1] && (req.x[COORD_W-2:0] < X_LIM) &&
		          !req.y[COORD_W-1] && (req.y[COORD_W-2:0] < Y_LIM);
		rd_addr = AW'(req.y[YW-1:0]) * WIDTH_A + AW'(req.x[XW-1:0]);
	end

	// Update rule on the value read back
	always_comb begin
		cur  = grid_rd_q;
		upd  = cur;
		sum  = {1'b0, cur} + {2'b00, free_weight};
		live = s1_q.valid && s1_q.inb && !s1_q.skip && (s1_q.kind != KIND_READ) &&
		       (mark_rd_q != epoch_q);
		case (s1_q.kind)
			KIND_HIT: begin
				if (cur > OCC_LOWER)
					upd = (cur > {1'b0, occ_weight}) ? cur - {1'b0, occ_weight} : '0;
			end
			KIND_FREE: begin
				if (cur < FREE_UPPER)
					upd = sum[CELL_W] ? {CELL_W{1'b1}} : sum[CELL_W-1:0];
			end
			default: upd = cur;
		endcase
	end

	// Write port: clearing sweep or read-modify-write
	always_comb begin
		grid_we = (sweep_q && sweep_grid_q) || live;
		mark_we = sweep_q || live;
		wr_addr = sweep_q ? sweep_addr_q : s1_q.addr;
		grid_wd = sweep_q ? CELL_UNKNOWN : upd;
		mark_wd = sweep_q ? '0 : epoch_q;
	end

	// Cell memory
	always_ff @(posedge clk) begin
		if (grid_we)
			grid_mem[wr_addr] <= grid_wd;
		grid_rd_q <= grid_mem[rd_addr];
	end

	// Frame tag memory
	always_ff @(posedge clk) begin
		if (mark_we)
			mark_mem[wr_addr] <= mark_wd;
		mark_rd_q <= mark_mem[rd_addr];
	end

	// Hold the access beside its read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
		end else begin
			s1_q.valid <= req.valid;
			s1_q.last  <= req.last;
			s1_q.skip  <= req.skip;
			s1_q.inb   <= req_inb;
			s1_q.kind  <= req.kind;
			s1_q.addr  <= rd_addr;
		end
	end

	// Frame tag and clearing sweep; a tag wrap clears all tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q      <= EPOCH_W'(1);
			sweep_q      <= 1'b1;
			sweep_grid_q <= 1'b1;
			sweep_addr_q <= '0;
		end else if (sweep_q) begin
			sweep_addr_q <= sweep_addr_q + 1'b1;
			if (sweep_addr_q == LAST_ADDR) begin
				sweep_q      <= 1'b0;
				sweep_grid_q <= 1'b0;
			end
		end else if (new_frame) begin
			if (epoch_q == {EPOCH_W{1'b1}}) begin
				epoch_q      <= EPOCH_W'(1);
				sweep_q      <= 1'b1;
				sweep_addr_q <= '0;
			end else begin
				epoch_q <= epoch_q + 1'b1;
			end
		end
	end

	assign rsp.valid  = s1_q.valid;
	assign rsp.last   = s1_q.last;
	assign rsp.acc    = live;
	assign rsp.value  = (s1_q.valid && s1_q.inb && s1_q.kind == KIND_READ) ? grid_rd_q : '0;
	assign sweep_busy = sweep_q;

	a_no_access_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_q |-> !req.valid && !s1_q.valid)
		else $error("cell access overlaps clearing sweep");

	a_acc_only_update: assert property (@(posedge clk) disable iff (!arst_n)
		live |-> s1_q.valid && s1_q.kind != KIND_READ && !s1_q.skip)
		else $error("cell accepted for an access that updates nothing");

	a_tag_never_zero: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != '0)
		else $error("frame tag equals the cleared tag");

endmodule
